@@ rtl/core/sida_pkg.sv @@
// shared types and constants for the signed integer to decimal text converter
package sida_pkg;

  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam int unsigned BCD_W     = 4;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONVERT,
    ST_LOCATE,
    ST_SIGN,
    ST_DIGITS
  } state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic locate;
    logic advance;
    logic sel_sign;
  } cmd_t;

  typedef struct packed {
    logic conv_done;
    logic neg;
    logic idx_zero;
  } stat_t;

endpackage

@@ rtl/core/sida_datapath.sv @@
// datapath: magnitude, iterative double dabble, digit select and character forming
module sida_datapath #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  sida_pkg::cmd_t                cmd,
  output sida_pkg::stat_t               stat,
  output logic [7:0]                    char_code
);

  localparam int NDIG = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCDW = NDIG * sida_pkg::BCD_W;
  localparam int CW   = $clog2(VALUE_WIDTH);
  localparam int IW   = $clog2(NDIG);

  logic [VALUE_WIDTH-1:0] bin_r, bin_nxt;
  logic [BCDW-1:0]        bcd_r, bcd_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [IW-1:0]          idx_r, idx_nxt;
  logic                   neg_r, neg_nxt;

  logic [VALUE_WIDTH-1:0] mag;
  logic [BCDW-1:0]        bcd_adj;
  logic [IW-1:0]          top;
  logic [3:0]             digit;

  // magnitude as unsigned, so the most negative value maps to 2^(w-1)
  assign mag = value[VALUE_WIDTH-1] ? (~value + 1'b1) : value;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] >= sida_pkg::BCD_ADJ_MIN) begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4] + sida_pkg::BCD_ADJ;
      end else begin
        bcd_adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  // highest nonzero digit, zero gives the lowest digit
  always_comb begin
    top = '0;
    for (int i = 1; i < NDIG; i++) begin
      if (bcd_r[i*4 +: 4] != 4'd0) begin
        top = IW'(i);
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    neg_nxt = neg_r;
    if (cmd.load) begin
      bin_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = '0;
      neg_nxt = value[VALUE_WIDTH-1];
    end else if (cmd.shift) begin
      bcd_nxt = {bcd_adj[BCDW-2:0], bin_r[VALUE_WIDTH-1]};
      bin_nxt = {bin_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd.locate) begin
      idx_nxt = top;
    end else if (cmd.advance) begin
      idx_nxt = idx_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
      neg_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      neg_r <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
  end

  assign digit = bcd_r[idx_r*4 +: 4];

  assign char_code = cmd.sel_sign ? sida_pkg::CHAR_MINUS
                                  : sida_pkg::CHAR_ZERO + {4'd0, digit};

  assign stat.conv_done = (cnt_r == CW'(VALUE_WIDTH - 1));
  assign stat.neg       = neg_r;
  assign stat.idx_zero  = (idx_r == '0);

endmodule

@@ rtl/core/sida_ctrl.sv @@
// controller state machine sequencing load, conversion, digit search and output
module sida_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output logic            out_last,
  input  sida_pkg::stat_t stat,
  output sida_pkg::cmd_t  cmd
);

  sida_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sida_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = sida_pkg::ST_CONVERT;
      end
      sida_pkg::ST_CONVERT: begin
        if (stat.conv_done) state_nxt = sida_pkg::ST_LOCATE;
      end
      sida_pkg::ST_LOCATE: begin
        state_nxt = stat.neg ? sida_pkg::ST_SIGN : sida_pkg::ST_DIGITS;
      end
      sida_pkg::ST_SIGN: begin
        if (out_ready) state_nxt = sida_pkg::ST_DIGITS;
      end
      sida_pkg::ST_DIGITS: begin
        if (out_ready && stat.idx_zero) state_nxt = sida_pkg::ST_IDLE;
      end
      default: state_nxt = sida_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    out_last  = 1'b0;
    case (state_r)
      sida_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      sida_pkg::ST_CONVERT: begin
        cmd.shift = 1'b1;
      end
      sida_pkg::ST_LOCATE: begin
        cmd.locate = 1'b1;
      end
      sida_pkg::ST_SIGN: begin
        out_valid    = 1'b1;
        cmd.sel_sign = 1'b1;
      end
      sida_pkg::ST_DIGITS: begin
        out_valid   = 1'b1;
        out_last    = stat.idx_zero;
        cmd.advance = out_ready && !stat.idx_zero;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sida_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ rtl/core/signed_int_to_decimal_ascii.sv @@
// top level: signed two's complement integer to decimal ascii character stream
// One request in gives its decimal text out, one character per transfer, most
// significant first, with a leading '-' for negative values, no leading zeros,
// and last set on the final character. A request is loaded, then converted by
// double dabble (the whole value shifted one bit per cycle through the bcd shift
// register), then the leading digit is found, then characters go out one per
// cycle when the output is not stalled. One request is in work at a time;
// in_ready is high only between requests.
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] in_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_char_code,
  output logic                          out_last
);

  sida_pkg::cmd_t  cmd;
  sida_pkg::stat_t stat;

  sida_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_last  (out_last),
    .stat      (stat),
    .cmd       (cmd)
  );

  sida_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .value     (in_value),
    .cmd       (cmd),
    .stat      (stat),
    .char_code (out_char_code)
  );

  a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready && !out_valid)
    else $error("request accepted while conversion still running");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("converter not idle after final character");

  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code == sida_pkg::CHAR_MINUS |-> !out_last)
    else $error("sign emitted as final character");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char_code != sida_pkg::CHAR_MINUS |->
      out_char_code >= sida_pkg::CHAR_ZERO && out_char_code <= 8'd57)
    else $error("character outside decimal digit range");

endmodule

@@ sim/signed_int_to_decimal_ascii_test.sv @@
// testbench for the signed integer to decimal ascii converter, checked against typed text and a text predictor
module signed_int_to_decimal_ascii_test;

  localparam int VALUE_W = 32;
  localparam int DEC_BASE = 10;
  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM_PHASE = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } text_char_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_char_code;
  logic out_last;

  text_char_t expected_chars[$];
  text_char_t want;
  int cycle_count = 0;
  int mismatch_count = 0;
  int requests_sent = 0;
  int negative_sent = 0;
  int chars_checked = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_req = 1'b0;

  logic signed [VALUE_W-1:0] row_value [N_DIRECTED] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0001, 32'sd1000000000,
    32'sd999999999, -32'sd999999999, -32'sd12345, 32'shffff_fffe,
    32'sh5555_5555, 32'shaaaa_aaaa, 32'sh0f0f_0f0f, 32'shf0f0_f0f0,
    32'sh0000_ffff, 32'shffff_0000
  };
  string row_text [N_DIRECTED] = '{
    "0", "1", "-1", "9", "10", "-10", "99", "100",
    "2147483647", "-2147483648", "-2147483647", "1000000000",
    "999999999", "-999999999", "-12345", "-2",
    "", "", "", "", "", ""
  };

  signed_int_to_decimal_ascii #(.VALUE_WIDTH(VALUE_W)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_char_code(out_char_code),
    .out_last(out_last)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding", cycle_count,
               expected_chars.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // append one expected character at the tail
  function automatic void queue_expected(input text_char_t c);
    expected_chars = {expected_chars, c};
  endfunction

  // decimal text of one value, sign first, no leading zeros
  function automatic void predict_decimal_text(input logic signed [VALUE_W-1:0] v);
    logic [VALUE_W:0] mag;
    logic [7:0] digits[$];
    text_char_t c;
    bit neg;
    neg = v[VALUE_W-1];
    mag = neg ? ({(VALUE_W+1){1'b0}} - {v[VALUE_W-1], v}) : {1'b0, v};
    do begin
      digits.push_front(sida_pkg::CHAR_ZERO + 8'(mag % DEC_BASE));
      mag = mag / DEC_BASE;
    end while (mag != 0);
    if (neg) begin
      c.code = sida_pkg::CHAR_MINUS;
      c.last = 1'b0;
      queue_expected(c);
    end
    foreach (digits[i]) begin
      c.code = digits[i];
      c.last = (i == digits.size() - 1);
      queue_expected(c);
    end
  endfunction

  function automatic void expect_typed_text(input string text);
    text_char_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.code = text[i];
      c.last = (i == text.len() - 1);
      queue_expected(c);
    end
  endfunction

  task automatic send_request(input logic signed [VALUE_W-1:0] v, input string text);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (text.len() != 0) expect_typed_text(text);
    else predict_decimal_text(v);
    requests_sent++;
    if (v < 0) negative_sent++;
    @(negedge clk);
  endtask

  function automatic logic signed [VALUE_W-1:0] random_value();
    logic signed [VALUE_W-1:0] v;
    int pow;
    case ($urandom_range(9))
      0: v = $urandom;
      1: v = $urandom_range(20);
      2: begin
        pow = 1;
        repeat ($urandom_range(9)) pow = pow * DEC_BASE;
        v = pow + $urandom_range(2) - 1;
      end
      3: v = $urandom_range(1) ? 32'sh7fff_ffff - $urandom_range(3)
                               : 32'sh8000_0000 + $urandom_range(3);
      default: v = $urandom >> $urandom_range(31);
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  initial begin
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("cycle %0d: unexpected character %0d last %0b", cycle_count,
                   out_char_code, out_last);
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (out_char_code !== want.code || out_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("cycle %0d: expected char %0d last %0b, got char %0d last %0b",
                     cycle_count, want.code, want.last, out_char_code, out_last);
        end
      end
    end
  end

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_DIRECTED; i++) send_request(row_value[i], row_text[i]);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      // long receiver hold-off while requests keep coming
      if (phase == 2) hold_req = 1'b1;
      for (int i = 0; i < N_RANDOM_PHASE; i++) send_request(random_value(), "");
    end
    in_valid <= 1'b0;

    while (expected_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d values converted (%0d negative), %0d characters checked, %0d mismatches",
             requests_sent, negative_sent, chars_checked, mismatch_count);
    $display("covered extremes, powers of ten, and four idle/stall mixes with a long hold-off");
    if (mismatch_count == 0 && expected_chars.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
